>>> rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on aclk, off while aresetn is low
`define STE_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off while aresetn is low
`define STE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/ste_pkg.sv
// shared types and constants of the semaphore table engine
`default_nettype none

package ste_pkg;

    localparam int CMD_W    = 2;
    localparam int ID_W     = 8;
    localparam int CNT_W    = 16;
    localparam int PID_W    = 8;
    localparam int STATUS_W = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_DESTROY = 2'd1,
        CMD_WAIT    = 2'd2,
        CMD_POST    = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_ID_RANGE   = 3'd1,
        ST_NONE_FREE  = 3'd2,
        ST_REFUSED    = 3'd3,
        ST_LIST_FULL  = 3'd4,
        ST_QUEUE_FULL = 3'd5
    } status_t;

    typedef struct packed {
        status_t status;
        logic    blocked;
        logic    wake;
        logic    ent_we;
        logic    pop;
        logic    push;
        logic    pid_we;
        logic    pid_re;
    } ctrl_t;

endpackage

`default_nettype wire

>>> rtl/ste_fwd_ram.sv
// one-write one-read store with registered read, per-entry valid bits and write bypass
`default_nettype none

module ste_fwd_ram #(
    parameter int DEPTH      = 16,
    parameter int WIDTH      = 8,
    parameter bit INDEX_INIT = 1'b0,
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] rd_reg;
    logic [WIDTH-1:0] fwd_reg;
    logic [AW-1:0]    rd_addr_reg;
    logic             rd_vld_reg;
    logic             hit_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_reg      <= mem[rd_addr];
            fwd_reg     <= wr_data;
            rd_addr_reg <= rd_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
            hit_reg    <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_vld_reg <= valid_reg[rd_addr];
                hit_reg    <= wr_en && (wr_addr == rd_addr);
            end
        end
    end

    // word written on the read edge wins, then stored word, then reset content
    always_comb begin
        priority if (hit_reg) begin
            rd_data = fwd_reg;
        end else if (rd_vld_reg) begin
            rd_data = rd_reg;
        end else begin
            rd_data = INDEX_INIT ? WIDTH'(rd_addr_reg) : '0;
        end
    end

endmodule

`default_nettype wire

>>> rtl/ste_decide.sv
// command decode and next-entry computation for one semaphore command
`default_nettype none

module ste_decide #(
    parameter int SEM_COUNT  = 16,
    parameter int WAIT_DEPTH = 16,
    localparam int IDW       = (SEM_COUNT > 1) ? $clog2(SEM_COUNT) : 1,
    localparam int LW        = $clog2(SEM_COUNT + 1),
    localparam int QW        = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1,
    localparam int SZW       = $clog2(WAIT_DEPTH + 1)
) (
    input  wire logic [ste_pkg::CMD_W-1:0] command,
    input  wire logic [ste_pkg::ID_W-1:0]  sem_id,
    input  wire logic [ste_pkg::CNT_W-1:0] initial_value,
    input  wire logic [ste_pkg::CNT_W-1:0] ent_count,
    input  wire logic [QW-1:0]             ent_head,
    input  wire logic [QW-1:0]             ent_tail,
    input  wire logic [SZW-1:0]            ent_size,
    input  wire logic [LW-1:0]             free_level,
    input  wire logic [IDW-1:0]            free_id,
    output ste_pkg::ctrl_t                 ctrl,
    output logic      [ste_pkg::CNT_W-1:0] new_count,
    output logic      [QW-1:0]             new_head,
    output logic      [QW-1:0]             new_tail,
    output logic      [SZW-1:0]            new_size,
    output logic      [ste_pkg::CNT_W-1:0] ret_value
);

    localparam logic [ste_pkg::ID_W:0] SEM_LIMIT = (ste_pkg::ID_W + 1)'(SEM_COUNT);
    localparam logic [QW-1:0]          LAST_SLOT = QW'(WAIT_DEPTH - 1);
    localparam int                     CNT_W_MAX_W = ste_pkg::CNT_W;
    localparam logic [CNT_W_MAX_W-1:0] CNT_MAX   = '1;

    ste_pkg::cmd_t cmd_e;
    logic          in_range;
    logic [QW-1:0] head_inc;
    logic [QW-1:0] tail_inc;

    assign cmd_e    = ste_pkg::cmd_t'(command);
    assign in_range = {1'b0, sem_id} < SEM_LIMIT;
    assign head_inc = (ent_head == LAST_SLOT) ? '0 : ent_head + 1'b1;
    assign tail_inc = (ent_tail == LAST_SLOT) ? '0 : ent_tail + 1'b1;

    always_comb begin
        ctrl        = '0;
        ctrl.status = ste_pkg::ST_OK;
        new_count   = ent_count;
        new_head    = ent_head;
        new_tail    = ent_tail;
        new_size    = ent_size;
        ret_value   = '0;
        unique case (cmd_e)
            ste_pkg::CMD_ALLOC: begin
                if (free_level == '0) begin
                    ctrl.status = ste_pkg::ST_NONE_FREE;
                end else begin
                    ctrl.pop    = 1'b1;
                    ctrl.ent_we = 1'b1;
                    new_count   = initial_value;
                    new_head    = '0;
                    new_tail    = '0;
                    new_size    = '0;
                    ret_value   = ste_pkg::CNT_W'(free_id);
                end
            end
            ste_pkg::CMD_DESTROY: begin
                priority if (!in_range) begin
                    ctrl.status = ste_pkg::ST_ID_RANGE;
                end else if (ent_count != '0) begin
                    ctrl.status = ste_pkg::ST_REFUSED;
                end else if (free_level >= LW'(SEM_COUNT)) begin
                    ctrl.status = ste_pkg::ST_LIST_FULL;
                end else begin
                    ctrl.push   = 1'b1;
                    ctrl.ent_we = 1'b1;
                    new_count   = '0;
                    new_head    = '0;
                    new_tail    = '0;
                    new_size    = '0;
                end
            end
            ste_pkg::CMD_WAIT: begin
                priority if (!in_range) begin
                    ctrl.status = ste_pkg::ST_ID_RANGE;
                end else if (ent_count != '0) begin
                    ctrl.ent_we = 1'b1;
                    new_count   = ent_count - 1'b1;
                    ret_value   = ent_count - 1'b1;
                end else if (ent_size >= SZW'(WAIT_DEPTH)) begin
                    ctrl.status = ste_pkg::ST_QUEUE_FULL;
                end else begin
                    ctrl.pid_we  = 1'b1;
                    ctrl.ent_we  = 1'b1;
                    ctrl.blocked = 1'b1;
                    new_tail     = tail_inc;
                    new_size     = ent_size + 1'b1;
                end
            end
            ste_pkg::CMD_POST: begin
                priority if (!in_range) begin
                    ctrl.status = ste_pkg::ST_ID_RANGE;
                end else if (ent_size != '0) begin
                    ctrl.pid_re = 1'b1;
                    ctrl.wake   = 1'b1;
                    ctrl.ent_we = 1'b1;
                    new_head    = head_inc;
                    new_size    = ent_size - 1'b1;
                    ret_value   = ent_count;
                end else begin
                    // count saturates at its top value
                    ctrl.ent_we = 1'b1;
                    new_count   = (ent_count == CNT_MAX) ? ent_count : ent_count + 1'b1;
                    ret_value   = (ent_count == CNT_MAX) ? ent_count : ent_count + 1'b1;
                end
            end
            default: begin
                ctrl.status = ste_pkg::ST_OK;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/semaphore_table_engine.sv
// top level of the semaphore table engine: input stage, stores and result register
`default_nettype none

// Counting semaphore table with a FIFO free list of ids and a FIFO wait queue per
// semaphore. Commands: allocate, destroy, wait, post. The block takes one word per
// cycle unless the result side stalls and returns one result word per command, in
// order; a word passes from the input stage register to the result register, and
// the pipeline holds two words when the result side stalls. The rate is set by the
// single read-modify-write pass over the semaphore entry store and the free list:
// both are read as the word is taken, with a bypass of the word written on that
// same edge, and written back when the word moves to the result register. The
// wait-pid store is read on that commit edge and its data is the wake_pid register.
// Reset clears every entry at once through valid bits, so there is no clearing pass.
module semaphore_table_engine #(
    parameter int SEM_COUNT  = 16,
    parameter int WAIT_DEPTH = 16
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [ste_pkg::CMD_W-1:0]    s_command,
    input  wire logic [ste_pkg::ID_W-1:0]     s_sem_id,
    input  wire logic [ste_pkg::CNT_W-1:0]    s_initial_value,
    input  wire logic [ste_pkg::PID_W-1:0]    s_caller_pid,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic      [ste_pkg::STATUS_W-1:0] m_status,
    output logic      [ste_pkg::CNT_W-1:0]    m_ret_value,
    output logic                              m_blocked,
    output logic                              m_wake_valid,
    output logic      [ste_pkg::PID_W-1:0]    m_wake_pid
);

    localparam int IDW       = (SEM_COUNT > 1) ? $clog2(SEM_COUNT) : 1;
    localparam int LW        = $clog2(SEM_COUNT + 1);
    localparam int QW        = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int SZW       = $clog2(WAIT_DEPTH + 1);
    localparam int ENT_W     = ste_pkg::CNT_W + 2 * QW + SZW;
    localparam int PID_DEPTH = SEM_COUNT * WAIT_DEPTH;
    localparam int PAW       = $clog2(PID_DEPTH);
    localparam int SW        = IDW + 2;

    // input stage
    logic                      s1_valid_reg;
    logic [ste_pkg::CMD_W-1:0] s1_cmd_reg;
    logic [ste_pkg::ID_W-1:0]  s1_id_reg;
    logic [ste_pkg::CNT_W-1:0] s1_init_reg;
    logic [ste_pkg::PID_W-1:0] s1_pid_reg;
    logic                      s_accept;
    logic                      s1_adv;

    // free list pointers
    logic [IDW-1:0] free_head_reg;
    logic [IDW-1:0] free_head_next;
    logic [IDW-1:0] free_head_inc;
    logic [LW-1:0]  free_level_reg;
    logic [LW-1:0]  free_level_next;
    logic [SW-1:0]  push_sum;
    logic [SW-1:0]  push_wrap;
    logic [IDW-1:0] free_id;

    // entry store
    logic [ENT_W-1:0]          ent_rdata;
    logic [ENT_W-1:0]          ent_wdata;
    logic [IDW-1:0]            ent_waddr;
    logic [IDW-1:0]            s1_idx;
    logic [ste_pkg::CNT_W-1:0] ent_count;
    logic [QW-1:0]             ent_head;
    logic [QW-1:0]             ent_tail;
    logic [SZW-1:0]            ent_size;
    logic [ste_pkg::CNT_W-1:0] new_count;
    logic [QW-1:0]             new_head;
    logic [QW-1:0]             new_tail;
    logic [SZW-1:0]            new_size;
    logic [ste_pkg::CNT_W-1:0] ret_value;
    ste_pkg::ctrl_t            ctrl;

    // wait pid store
    logic [ste_pkg::PID_W-1:0] pid_mem [PID_DEPTH];
    logic [ste_pkg::PID_W-1:0] pid_rd_reg;
    logic [PAW-1:0]            pid_base;
    logic [PAW-1:0]            pid_waddr;
    logic [PAW-1:0]            pid_raddr;

    // result register
    logic                      m_valid_reg;
    ste_pkg::status_t          m_status_reg;
    logic [ste_pkg::CNT_W-1:0] m_ret_reg;
    logic                      m_blocked_reg;
    logic                      m_wake_reg;

    assign s1_adv   = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !s1_valid_reg || s1_adv;
    assign s_accept = s_valid && s_ready;
    assign s1_idx   = s1_id_reg[IDW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_cmd_reg  <= s_command;
            s1_id_reg   <= s_sem_id;
            s1_init_reg <= s_initial_value;
            s1_pid_reg  <= s_caller_pid;
        end
    end

    // free list head, level and push slot
    assign free_head_inc = (free_head_reg == IDW'(SEM_COUNT - 1)) ? '0 : free_head_reg + 1'b1;
    assign push_sum      = SW'(free_head_reg) + SW'(free_level_reg);
    assign push_wrap     = (push_sum >= SW'(SEM_COUNT)) ? push_sum - SW'(SEM_COUNT) : push_sum;

    always_comb begin
        free_head_next  = free_head_reg;
        free_level_next = free_level_reg;
        if (s1_adv && ctrl.pop) begin
            free_head_next  = free_head_inc;
            free_level_next = free_level_reg - 1'b1;
        end else if (s1_adv && ctrl.push) begin
            free_level_next = free_level_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_head_reg  <= '0;
            free_level_reg <= LW'(SEM_COUNT);
        end else begin
            free_head_reg  <= free_head_next;
            free_level_reg <= free_level_next;
        end
    end

    ste_fwd_ram #(
        .DEPTH      (SEM_COUNT),
        .WIDTH      (IDW),
        .INDEX_INIT (1'b1)
    ) u_free_list (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_accept),
        .rd_addr (free_head_next),
        .wr_en   (s1_adv && ctrl.push),
        .wr_addr (push_wrap[IDW-1:0]),
        .wr_data (s1_idx),
        .rd_data (free_id)
    );

    // entry: count, queue head, queue tail, queue size
    assign {ent_count, ent_head, ent_tail, ent_size} = ent_rdata;
    assign ent_wdata = {new_count, new_head, new_tail, new_size};
    assign ent_waddr = ctrl.pop ? free_id : s1_idx;

    ste_fwd_ram #(
        .DEPTH      (SEM_COUNT),
        .WIDTH      (ENT_W),
        .INDEX_INIT (1'b0)
    ) u_entry_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_accept),
        .rd_addr (s_sem_id[IDW-1:0]),
        .wr_en   (s1_adv && ctrl.ent_we),
        .wr_addr (ent_waddr),
        .wr_data (ent_wdata),
        .rd_data (ent_rdata)
    );

    ste_decide #(
        .SEM_COUNT  (SEM_COUNT),
        .WAIT_DEPTH (WAIT_DEPTH)
    ) u_decide (
        .command       (s1_cmd_reg),
        .sem_id        (s1_id_reg),
        .initial_value (s1_init_reg),
        .ent_count     (ent_count),
        .ent_head      (ent_head),
        .ent_tail      (ent_tail),
        .ent_size      (ent_size),
        .free_level    (free_level_reg),
        .free_id       (free_id),
        .ctrl          (ctrl),
        .new_count     (new_count),
        .new_head      (new_head),
        .new_tail      (new_tail),
        .new_size      (new_size),
        .ret_value     (ret_value)
    );

    // wait pid store, one row of WAIT_DEPTH slots per semaphore
    assign pid_base  = PAW'(s1_idx) * PAW'(WAIT_DEPTH);
    assign pid_waddr = pid_base + PAW'(ent_tail);
    assign pid_raddr = pid_base + PAW'(ent_head);

    always_ff @(posedge aclk) begin
        if (s1_adv && ctrl.pid_we) begin
            pid_mem[pid_waddr] <= s1_pid_reg;
        end
        if (s1_adv && ctrl.pid_re) begin
            pid_rd_reg <= pid_mem[pid_raddr];
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_status_reg  <= ctrl.status;
            m_ret_reg     <= ret_value;
            m_blocked_reg <= ctrl.blocked;
            m_wake_reg    <= ctrl.wake;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_ret_value  = m_ret_reg;
    assign m_blocked    = m_blocked_reg;
    assign m_wake_valid = m_wake_reg;
    assign m_wake_pid   = m_wake_reg ? pid_rd_reg : '0;

endmodule

`default_nettype wire

>>> rtl/ste_checker.sv
// port-level checker for the semaphore table engine and its bind
`default_nettype none

`include "assert_macros.svh"

module ste_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         s_valid,
    input wire logic                         s_ready,
    input wire logic [ste_pkg::CMD_W-1:0]    s_command,
    input wire logic [ste_pkg::ID_W-1:0]     s_sem_id,
    input wire logic [ste_pkg::CNT_W-1:0]    s_initial_value,
    input wire logic [ste_pkg::PID_W-1:0]    s_caller_pid,
    input wire logic                         m_valid,
    input wire logic                         m_ready,
    input wire logic [ste_pkg::STATUS_W-1:0] m_status,
    input wire logic [ste_pkg::CNT_W-1:0]    m_ret_value,
    input wire logic                         m_blocked,
    input wire logic                         m_wake_valid,
    input wire logic [ste_pkg::PID_W-1:0]    m_wake_pid
);

    // a stalled result word holds
    `STE_ASSERT_NEXT(a_result_hold, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_ret_value) && $stable(m_blocked) && $stable(m_wake_valid) && $stable(m_wake_pid), "result word changed while stalled")

    // two words in flight behind a stalled result leave no room
    `STE_ASSERT(a_two_deep, $past(aresetn) && $past(m_valid && !m_ready) && $past(s_valid && s_ready) && m_valid && !m_ready, !s_ready, "input taken with pipeline full")

    // a failed command reports nothing else
    `STE_ASSERT(a_error_clean, m_valid && (m_status != ste_pkg::ST_OK), (m_ret_value == '0) && !m_blocked && !m_wake_valid, "error word carries data")

    // blocking and waking exclude each other, and a blocked wait returns zero
    `STE_ASSERT(a_block_wake, m_valid && m_blocked, !m_wake_valid && (m_ret_value == '0), "blocked word with wake or count")

    // no wake pid without a wake
    `STE_ASSERT(a_wake_pid_zero, m_valid && !m_wake_valid, m_wake_pid == '0, "wake pid without wake")

endmodule

bind semaphore_table_engine ste_checker u_ste_checker (.*);

`default_nettype wire

>>> sim/semaphore_table_engine_tb.sv
// self-checking testbench of the semaphore table engine with its own table predictor
`timescale 1ns / 1ps

module semaphore_table_engine_tb;

    localparam int NSEM      = 16;
    localparam int QDEPTH    = 16;
    localparam int N_WORDS   = 1050;
    localparam int N_PLAN    = 22;

    typedef struct packed {
        ste_pkg::status_t                status;
        logic [ste_pkg::CNT_W-1:0]       ret;
        logic                            blocked;
        logic                            wake;
        logic [ste_pkg::PID_W-1:0]       wpid;
    } result_t;

    typedef struct {
        ste_pkg::cmd_t                   cmd;
        logic [ste_pkg::ID_W-1:0]        id;
        logic [ste_pkg::CNT_W-1:0]       init;
        logic [ste_pkg::PID_W-1:0]       pid;
        int                              reps;
        bit                              typed;
        result_t                         want;
    } plan_row_t;

    logic                         aclk            = 1'b0;
    logic                         aresetn         = 1'b0;
    logic                         s_valid         = 1'b0;
    logic                         s_ready;
    logic [ste_pkg::CMD_W-1:0]    s_command       = '0;
    logic [ste_pkg::ID_W-1:0]     s_sem_id        = '0;
    logic [ste_pkg::CNT_W-1:0]    s_initial_value = '0;
    logic [ste_pkg::PID_W-1:0]    s_caller_pid    = '0;
    logic                         m_valid;
    logic                         m_ready         = 1'b0;
    logic [ste_pkg::STATUS_W-1:0] m_status;
    logic [ste_pkg::CNT_W-1:0]    m_ret_value;
    logic                         m_blocked;
    logic                         m_wake_valid;
    logic [ste_pkg::PID_W-1:0]    m_wake_pid;

    // table state as the block should hold it
    logic [ste_pkg::CNT_W-1:0]    sem_cnt [NSEM];
    int                           free_ids [NSEM];
    int                           free_rd;
    int                           free_lvl;
    logic [ste_pkg::PID_W-1:0]    pid_ring [NSEM][QDEPTH];
    int                           q_head [NSEM];
    int                           q_tail [NSEM];
    int                           q_size [NSEM];

    result_t             expected_q [$];
    int                  errors     = 0;
    int                  words_sent = 0;
    bit                  steady     = 1'b0;
    int                  stall_left = 0;

    plan_row_t plan [N_PLAN] = '{
        '{ste_pkg::CMD_DESTROY, 8'd0,   16'd0,     8'd0,   1, 1'b1,
          '{ste_pkg::ST_LIST_FULL, 16'd0, 1'b0, 1'b0, 8'd0}},
        '{ste_pkg::CMD_WAIT,    8'd255, 16'hFFFF,  8'hAA,  1, 1'b1,
          '{ste_pkg::ST_ID_RANGE, 16'd0, 1'b0, 1'b0, 8'd0}},
        '{ste_pkg::CMD_POST,    8'd16,  16'd0,     8'h55,  1, 1'b1,
          '{ste_pkg::ST_ID_RANGE, 16'd0, 1'b0, 1'b0, 8'd0}},
        '{ste_pkg::CMD_DESTROY, 8'd128, 16'd0,     8'd0,   1, 1'b1,
          '{ste_pkg::ST_ID_RANGE, 16'd0, 1'b0, 1'b0, 8'd0}},
        '{ste_pkg::CMD_POST,    8'd15,  16'd0,     8'd0,   1, 1'b1,
          '{ste_pkg::ST_OK, 16'd1, 1'b0, 1'b0, 8'd0}},
        '{ste_pkg::CMD_ALLOC,   8'd255, 16'hFFFF,  8'd0,   1, 1'b1,
          '{ste_pkg::ST_OK, 16'd0, 1'b0, 1'b0, 8'd0}},
        '{ste_pkg::CMD_POST,    8'd0,   16'd0,     8'd0,   1, 1'b1,
          '{ste_pkg::ST_OK, 16'hFFFF, 1'b0, 1'b0, 8'd0}},
        '{ste_pkg::CMD_DESTROY, 8'd0,   16'd0,     8'd0,   1, 1'b1,
          '{ste_pkg::ST_REFUSED, 16'd0, 1'b0, 1'b0, 8'd0}},
        '{ste_pkg::CMD_WAIT,    8'd0,   16'd0,     8'd0,   1, 1'b1,
          '{ste_pkg::ST_OK, 16'hFFFE, 1'b0, 1'b0, 8'd0}},
        '{ste_pkg::CMD_ALLOC,   8'd0,   16'd0,     8'd0,   1, 1'b1,
          '{ste_pkg::ST_OK, 16'd1, 1'b0, 1'b0, 8'd0}},
        '{ste_pkg::CMD_WAIT,    8'd1,   16'd0,     8'hFF,  1, 1'b1,
          '{ste_pkg::ST_OK, 16'd0, 1'b1, 1'b0, 8'd0}},
        '{ste_pkg::CMD_WAIT,    8'd1,   16'd0,     8'h00,  1, 1'b1,
          '{ste_pkg::ST_OK, 16'd0, 1'b1, 1'b0, 8'd0}},
        '{ste_pkg::CMD_POST,    8'd1,   16'd0,     8'd0,   1, 1'b1,
          '{ste_pkg::ST_OK, 16'd0, 1'b0, 1'b1, 8'hFF}},
        '{ste_pkg::CMD_POST,    8'd1,   16'd0,     8'd0,   1, 1'b1,
          '{ste_pkg::ST_OK, 16'd0, 1'b0, 1'b1, 8'h00}},
        '{ste_pkg::CMD_POST,    8'd1,   16'd0,     8'd0,   1, 1'b0, '0},
        '{ste_pkg::CMD_WAIT,    8'd1,   16'd0,     8'd0,   1, 1'b0, '0},
        '{ste_pkg::CMD_DESTROY, 8'd1,   16'd0,     8'd0,   1, 1'b1,
          '{ste_pkg::ST_OK, 16'd0, 1'b0, 1'b0, 8'd0}},
        '{ste_pkg::CMD_WAIT,    8'd2,   16'd0,     8'h5A, 16, 1'b0, '0},
        '{ste_pkg::CMD_WAIT,    8'd2,   16'd0,     8'hA5,  1, 1'b1,
          '{ste_pkg::ST_QUEUE_FULL, 16'd0, 1'b0, 1'b0, 8'd0}},
        '{ste_pkg::CMD_POST,    8'd2,   16'd0,     8'd0,  16, 1'b0, '0},
        '{ste_pkg::CMD_ALLOC,   8'd0,   16'h8000,  8'd0,  15, 1'b0, '0},
        '{ste_pkg::CMD_ALLOC,   8'd0,   16'd0,     8'd0,   1, 1'b1,
          '{ste_pkg::ST_NONE_FREE, 16'd0, 1'b0, 1'b0, 8'd0}}
    };

    semaphore_table_engine #(
        .SEM_COUNT  (NSEM),
        .WAIT_DEPTH (QDEPTH)
    ) i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_sem_id        (s_sem_id),
        .s_initial_value (s_initial_value),
        .s_caller_pid    (s_caller_pid),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_ret_value     (m_ret_value),
        .m_blocked       (m_blocked),
        .m_wake_valid    (m_wake_valid),
        .m_wake_pid      (m_wake_pid)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic void clear_sem(int k);
        sem_cnt[k] = '0;
        q_head[k]  = 0;
        q_tail[k]  = 0;
        q_size[k]  = 0;
    endfunction

    function automatic result_t apply_cmd(ste_pkg::cmd_t c, logic [ste_pkg::ID_W-1:0] id,
                                          logic [ste_pkg::CNT_W-1:0] init,
                                          logic [ste_pkg::PID_W-1:0] pid);
        result_t r;
        int      k;
        r = '{ste_pkg::ST_OK, 16'd0, 1'b0, 1'b0, 8'd0};
        k = int'(id);
        if (c == ste_pkg::CMD_ALLOC) begin
            if (free_lvl == 0) begin
                r.status = ste_pkg::ST_NONE_FREE;
            end else begin
                k = free_ids[free_rd];
                free_rd = (free_rd + 1) % NSEM;
                free_lvl--;
                clear_sem(k);
                sem_cnt[k] = init;
                r.ret = ste_pkg::CNT_W'(k);
            end
        end else if (k >= NSEM) begin
            r.status = ste_pkg::ST_ID_RANGE;
        end else if (c == ste_pkg::CMD_DESTROY) begin
            if (sem_cnt[k] != 0) begin
                r.status = ste_pkg::ST_REFUSED;
            end else if (free_lvl >= NSEM) begin
                r.status = ste_pkg::ST_LIST_FULL;
            end else begin
                free_ids[(free_rd + free_lvl) % NSEM] = k;
                free_lvl++;
                clear_sem(k);
            end
        end else if (c == ste_pkg::CMD_WAIT) begin
            if (sem_cnt[k] == 0) begin
                if (q_size[k] >= QDEPTH) begin
                    r.status = ste_pkg::ST_QUEUE_FULL;
                end else begin
                    pid_ring[k][q_tail[k]] = pid;
                    q_tail[k] = (q_tail[k] + 1) % QDEPTH;
                    q_size[k]++;
                    r.blocked = 1'b1;
                end
            end else begin
                sem_cnt[k]--;
                r.ret = sem_cnt[k];
            end
        end else begin
            if (q_size[k] > 0) begin
                r.wpid = pid_ring[k][q_head[k]];
                q_head[k] = (q_head[k] + 1) % QDEPTH;
                q_size[k]--;
                r.wake = 1'b1;
            end else if (sem_cnt[k] != 16'hFFFF) begin
                sem_cnt[k]++;
            end
            r.ret = sem_cnt[k];
        end
        return r;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0) return int'($urandom_range(8, 30));
        return int'($urandom_range(1, 3));
    endfunction

    function automatic logic [ste_pkg::PID_W-1:0] rand_pid();
        return ste_pkg::PID_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [ste_pkg::CNT_W-1:0] rand_cnt();
        return ste_pkg::CNT_W'($urandom_range(0, 16'hFFFF));
    endfunction

    task automatic send_word(input ste_pkg::cmd_t c, input logic [ste_pkg::ID_W-1:0] id,
                             input logic [ste_pkg::CNT_W-1:0] init,
                             input logic [ste_pkg::PID_W-1:0] pid,
                             input bit typed, input result_t want);
        int      gap;
        result_t got;
        gap = (!steady && $urandom_range(0, 99) < 40) ? gap_len() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_command       <= c;
        s_sem_id        <= id;
        s_initial_value <= init;
        s_caller_pid    <= pid;
        do @(posedge aclk); while (!s_ready);
        got = apply_cmd(c, id, init, pid);
        expected_q.push_back(typed ? want : got);
        words_sent++;
    endtask

    function automatic logic [ste_pkg::ID_W-1:0] pick_id(bit want_idle);
        int idle [$];
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 8) return ste_pkg::ID_W'($urandom_range(NSEM, 255));
        if (want_idle && r < 80) begin
            foreach (sem_cnt[i]) begin
                if (sem_cnt[i] == 0) idle.push_back(i);
            end
            if (idle.size() != 0) begin
                return ste_pkg::ID_W'(idle[$urandom_range(0, idle.size() - 1)]);
            end
        end
        return ste_pkg::ID_W'($urandom_range(0, NSEM - 1));
    endfunction

    function automatic logic [ste_pkg::CNT_W-1:0] alloc_init();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 50) return '0;
        if (r < 90) return ste_pkg::CNT_W'($urandom_range(1, 4));
        if (r < 96) return ste_pkg::CNT_W'(16'hFFFF - $urandom_range(0, 1));
        return rand_cnt();
    endfunction

    task automatic random_word();
        ste_pkg::cmd_t c;
        int            r;
        r = int'($urandom_range(0, 99));
        c = (r < 15) ? ste_pkg::CMD_ALLOC :
            (r < 30) ? ste_pkg::CMD_DESTROY :
            (r < 65) ? ste_pkg::CMD_WAIT : ste_pkg::CMD_POST;
        send_word(c, pick_id(c == ste_pkg::CMD_DESTROY),
                  (c == ste_pkg::CMD_ALLOC) ? alloc_init() : rand_cnt(),
                  rand_pid(), 1'b0, '0);
    endtask

    task automatic wait_burst();
        logic [ste_pkg::ID_W-1:0] id;
        int                       n;
        id = ste_pkg::ID_W'($urandom_range(0, NSEM - 1));
        n  = int'($urandom_range(1, QDEPTH + 2));
        repeat (n) send_word(ste_pkg::CMD_WAIT, id, rand_cnt(), rand_pid(), 1'b0, '0);
        repeat ($urandom_range(0, n + 2)) begin
            send_word(ste_pkg::CMD_POST, id, rand_cnt(), rand_pid(), 1'b0, '0);
        end
    endtask

    task automatic churn();
        logic [ste_pkg::ID_W-1:0] id;
        id = pick_id(1'b1);
        send_word(ste_pkg::CMD_DESTROY, id, rand_cnt(), rand_pid(), 1'b0, '0);
        send_word(ste_pkg::CMD_ALLOC, ste_pkg::ID_W'($urandom_range(0, 255)), alloc_init(),
                  rand_pid(), 1'b0, '0);
        send_word(ste_pkg::CMD_WAIT, id, rand_cnt(), rand_pid(), 1'b0, '0);
    endtask

    task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // result side: check each accepted word and stall at random
    initial begin
        result_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: result word with nothing expected, status %0d ret %0d",
                             $time, m_status, m_ret_value);
                    errors++;
                end else begin
                    want = expected_q.pop_front();
                    cmp_field("status", 32'(want.status), 32'(m_status));
                    cmp_field("ret_value", 32'(want.ret), 32'(m_ret_value));
                    cmp_field("blocked", 32'(want.blocked), 32'(m_blocked));
                    cmp_field("wake_valid", 32'(want.wake), 32'(m_wake_valid));
                    cmp_field("wake_pid", 32'(want.wpid), 32'(m_wake_pid));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!steady && $urandom_range(0, 99) < 25) begin
                stall_left = gap_len() - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        int kind;
        for (int i = 0; i < NSEM; i++) begin
            clear_sem(i);
            free_ids[i] = i;
        end
        free_rd  = 0;
        free_lvl = NSEM;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            repeat (plan[i].reps) begin
                send_word(plan[i].cmd, plan[i].id, plan[i].init, plan[i].pid,
                          plan[i].typed, plan[i].want);
            end
        end

        while (words_sent < N_WORDS) begin
            steady = ($urandom_range(0, 9) == 0);
            kind   = int'($urandom_range(0, 9));
            if (kind < 6) begin
                repeat (8) random_word();
            end else if (kind < 8) begin
                wait_burst();
            end else begin
                churn();
            end
        end
        s_valid <= 1'b0;
        steady = 1'b0;

        while (expected_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/ste_pkg.sv
rtl/ste_fwd_ram.sv
rtl/ste_decide.sv
rtl/semaphore_table_engine.sv
rtl/ste_checker.sv
sim/semaphore_table_engine_tb.sv
